// File: hdl/sfm13_pkg.sv
`default_nettype none

package sfm13_pkg;

    // Frame clock numbers
    localparam logic [3:0] StatusClock = 4'd12;
    localparam logic [3:0] DataFirst   = 4'd4;
    localparam logic [3:0] DataLast    = 4'd11;
    localparam logic [3:0] DirClock    = 4'd2;
    localparam logic [3:0] SelClock    = 4'd3;
    localparam logic [3:0] StartClock  = 4'd1;

    // One input beat
    typedef struct packed {
        logic       command;
        logic       read_not_write;
        logic       register_select;
        logic [7:0] write_byte;
        logic       miso_level;
    } item_t;

    // One result beat
    typedef struct packed {
        logic       chip_select;
        logic       mosi_level;
        logic       clock_pulse;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       status_ok;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/sfm13_in_stage.sv
`default_nettype none

module sfm13_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sfm13_pkg::item_t item_in,
    input  wire logic           advance,
    output logic                item_valid,
    output sfm13_pkg::item_t    item_out
);

    logic             valid_reg;
    sfm13_pkg::item_t item_reg;

    // Hold the registered beat while the engine cannot take it.
    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_in;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sfm13_engine.sv
`default_nettype none

module sfm13_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire sfm13_pkg::item_t item,
    output logic                  advance,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output sfm13_pkg::result_t    result
);

    logic [3:0] clock_index_reg, clock_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic       direction_read_reg, direction_read_next;
    logic       status_select_reg, status_select_next;
    logic       status_sample_reg, status_sample_next;
    logic       active_reg, active_next;
    logic       out_valid_reg;
    sfm13_pkg::result_t result_reg;
    sfm13_pkg::result_t res;
    logic [3:0] k;
    logic [3:0] bit_pos;

    assign advance   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        clock_index_next    = clock_index_reg;
        shift_byte_next     = shift_byte_reg;
        direction_read_next = direction_read_reg;
        status_select_next  = status_select_reg;
        status_sample_next  = status_sample_reg;
        active_next         = active_reg;
        res                 = '0;
        k                   = clock_index_reg + 4'd1;
        bit_pos             = sfm13_pkg::DataLast - k;

        if (item.command)
        begin
            // Start is dropped while a frame is running.
            if (!active_reg)
            begin
                direction_read_next = item.read_not_write;
                status_select_next  = item.register_select;
                shift_byte_next     = item.read_not_write ? 8'd0 : item.write_byte;
                status_sample_next  = 1'b0;
                clock_index_next    = 4'd0;
                active_next         = 1'b1;
            end
            res.chip_select = (clock_index_next < sfm13_pkg::StatusClock);
            res.busy_res    = 1'b1;
        end
        else if (active_reg)
        begin
            clock_index_next = k;
            res.clock_pulse  = 1'b1;
            res.chip_select  = 1'b1;
            res.busy_res     = 1'b1;
            if (k == sfm13_pkg::StartClock)
            begin
                res.mosi_level = 1'b1;
            end
            else if (k == sfm13_pkg::DirClock)
            begin
                res.mosi_level = direction_read_reg;
            end
            else if (k == sfm13_pkg::SelClock)
            begin
                res.mosi_level = status_select_reg;
            end
            else if (k >= sfm13_pkg::DataFirst && k <= sfm13_pkg::DataLast)
            begin
                if (direction_read_reg)
                begin
                    shift_byte_next = {shift_byte_reg[6:0], item.miso_level};
                end
                else
                begin
                    res.mosi_level = shift_byte_reg[bit_pos[2:0]];
                end
            end
            else
            begin
                // Hold the last data level on the status and final clocks.
                res.mosi_level = !direction_read_reg && shift_byte_reg[0];
                if (k == sfm13_pkg::StatusClock)
                begin
                    status_sample_next = item.miso_level;
                end
                else
                begin
                    res.chip_select  = 1'b0;
                    res.busy_res     = 1'b0;
                    res.done_res     = 1'b1;
                    res.read_byte    = direction_read_reg ? shift_byte_reg : 8'd0;
                    res.status_ok    = !status_sample_reg;
                    active_next      = 1'b0;
                    clock_index_next = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_index_reg    <= 4'd0;
            shift_byte_reg     <= 8'd0;
            direction_read_reg <= 1'b0;
            status_select_reg  <= 1'b0;
            status_sample_reg  <= 1'b0;
            active_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
            if (item_valid)
            begin
                clock_index_reg    <= clock_index_next;
                shift_byte_reg     <= shift_byte_next;
                direction_read_reg <= direction_read_next;
                status_select_reg  <= status_select_next;
                status_sample_reg  <= status_sample_next;
                active_reg         <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= res;
        end
    end

`ifndef NO_ASSERTIONS
    a_fell_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(clock_index_reg) == sfm13_pkg::StatusClock)
        else $error("frame ended before the status clock");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        clock_index_reg <= sfm13_pkg::StatusClock)
        else $error("clock index out of range");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> clock_index_reg == 4'd0)
        else $error("idle with nonzero clock index");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.done_res |->
            !result_reg.chip_select && !result_reg.busy_res && result_reg.clock_pulse)
        else $error("done beat has wrong select, busy or pulse");
`endif

endmodule

`default_nettype wire

// File: hdl/spi_frame_master_13_clock.sv
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  -----------------------------------------------
// input    in_valid / in_stall  command, read_not_write, register_select,
//                               write_byte, miso_level
// output   out_valid / out_stall chip_select, mosi_level, clock_pulse, busy_res,
//                               done_res, read_byte, status_ok
//
// Every input beat gives exactly one result beat, via the input register and
// then the result register. One beat per cycle is sustained while out_stall is
// low; a new beat can enter while a finished result still waits on out_stall.
// Frame state updates only when a beat moves into the result register.
// rst_n clears the frame state and both valid flags; payload is not reset.

module spi_frame_master_13_clock (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       command,
    input  wire logic       read_not_write,
    input  wire logic       register_select,
    input  wire logic [7:0] write_byte,
    input  wire logic       miso_level,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            chip_select,
    output logic            mosi_level,
    output logic            clock_pulse,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_byte,
    output logic            status_ok
);

    sfm13_pkg::item_t   item_in;
    sfm13_pkg::item_t   item;
    sfm13_pkg::result_t result;
    logic               item_valid;
    logic               advance;

    // Pack the input beat.
    always_comb
    begin
        item_in.command         = command;
        item_in.read_not_write  = read_not_write;
        item_in.register_select = register_select;
        item_in.write_byte      = write_byte;
        item_in.miso_level      = miso_level;
    end

    // Input register: holds one beat, stalls while that beat cannot advance.
    sfm13_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    // Frame sequencer and result register.
    sfm13_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    // Unpack the result beat.
    assign chip_select = result.chip_select;
    assign mosi_level  = result.mosi_level;
    assign clock_pulse = result.clock_pulse;
    assign busy_res    = result.busy_res;
    assign done_res    = result.done_res;
    assign read_byte   = result.read_byte;
    assign status_ok   = result.status_ok;

endmodule

`default_nettype wire
